### hw/rtl/dssw_pkg.sv
// Shared types, constants and the seven-segment font for the display writer.
// Used by dssw_div10, dssw_seq and decimal_seven_segment_writer.
// No dependencies.
`timescale 1ns / 1ps

package dssw_pkg;

    // field widths
    localparam int FUNC_W  = 2;
    localparam int FREQ_W  = 31;
    localparam int ID_W    = 7;
    localparam int VALUE_W = 16;
    localparam int LEVEL_W = 8;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 8;
    localparam int LVL_W   = 4;
    localparam int CNT_W   = 4;
    localparam int DIGIT_W = 4;

    // default display geometry
    localparam int NUM_DIGITS_DEF   = 8;
    localparam int VALUE_DIGITS_DEF = 5;

    // at most this many register writes per command
    localparam logic [CNT_W-1:0] MAX_WRITES = 4'd15;

    // driver register addresses
    localparam logic [ADDR_W-1:0] ADDR_INTENSITY = 4'd10;
    localparam logic [ADDR_W-1:0] ADDR_SHUTDOWN  = 4'd12;

    // positions that carry a decimal point on a frequency draw wherever a digit is drawn
    localparam logic [ADDR_W-1:0] POINT_POS_A = 4'd4;
    localparam logic [ADDR_W-1:0] POINT_POS_B = 4'd7;

    // segment bytes
    localparam logic [DATA_W-1:0] SEG_POINT = 8'h80;
    localparam logic [DATA_W-1:0] SEG_MINUS = 8'h01;
    localparam logic [DATA_W-1:0] SEG_BLANK = 8'h00;

    localparam logic [LVL_W-1:0] LVL_MAX = 4'd15;

    // reciprocal of ten, scaled by 2^35
    localparam logic [31:0] DIV_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV_SHIFT = 35;
    localparam int          PROD_W    = FREQ_W + 32;
    localparam int          QUOT_W    = PROD_W - DIV_SHIFT;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_FREQ  = 2'd0,
        FUNC_MENU  = 2'd1,
        FUNC_LEVEL = 2'd2
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FREQ,
        ST_CLEAR,
        ST_ID_LO,
        ST_ID_HI,
        ST_VALUE,
        ST_LEVEL_ON,
        ST_LEVEL_SET,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic              start;
        logic [FREQ_W-1:0] x;
    } t_div_req;

    typedef struct packed {
        logic               valid;
        logic [FREQ_W-1:0]  q;
        logic [DIGIT_W-1:0] r;
    } t_div_rsp;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_wr;

    // seven-segment pattern of one decimal digit
    function automatic logic [DATA_W-1:0] seg_font(input logic [DIGIT_W-1:0] digit);
        logic [DATA_W-1:0] pat;
        unique case (digit)
            4'd0:    pat = 8'h7E;
            4'd1:    pat = 8'h30;
            4'd2:    pat = 8'h6D;
            4'd3:    pat = 8'h79;
            4'd4:    pat = 8'h33;
            4'd5:    pat = 8'h5B;
            4'd6:    pat = 8'h5F;
            4'd7:    pat = 8'h70;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h7B;
            default: pat = SEG_BLANK;
        endcase
        return pat;
    endfunction

endpackage

### hw/rtl/decimal_seven_segment_writer.sv
// Decimal seven-segment writer top level: sequencer, divide unit, output register.
// Depends on dssw_pkg, dssw_div10 and dssw_seq.
//
// Usage: one command is taken per input transfer (i_valid / o_ready). It turns
// into zero to fifteen register writes (address, byte) for an eight-digit LED
// driver, sent as output transfers (o_valid / i_ready); o_last_write marks the
// final write of a command. A frequency command equal in i_freq and i_cw to the one
// last drawn gives no writes.
// Every decimal digit goes through the shared divide-by-ten unit. o_ready is high
// only while no command is in work.
// The output register holds one write; while the receiver stalls, one more
// write waits inside and the sequencer pauses. A command may be accepted while
// the final write of the previous one still waits to be taken.
// Reset clears the stored frequency, the stored brightness and all handshakes;
// the next frequency command is always drawn.
`timescale 1ns / 1ps

module decimal_seven_segment_writer #(
    parameter int NUM_DIGITS   = dssw_pkg::NUM_DIGITS_DEF,
    parameter int VALUE_DIGITS = dssw_pkg::VALUE_DIGITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [dssw_pkg::FUNC_W-1:0]         i_func,
    input  logic [dssw_pkg::FREQ_W-1:0]         i_freq,
    input  logic                                i_cw,
    input  logic [dssw_pkg::ID_W-1:0]           i_menu_id,
    input  logic signed [dssw_pkg::VALUE_W-1:0] i_menu_value,
    input  logic                                i_edit_mark,
    input  logic [dssw_pkg::LEVEL_W-1:0]        i_level,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [dssw_pkg::ADDR_W-1:0]         o_reg_addr,
    output logic [dssw_pkg::DATA_W-1:0]         o_reg_data,
    output logic                                o_last_write
);

    dssw_pkg::t_div_req w_div_req;
    dssw_pkg::t_div_rsp w_div_rsp;
    dssw_pkg::t_wr      w_push;
    logic               w_out_free;

    logic                        r_out_v;
    logic [dssw_pkg::ADDR_W-1:0] r_out_addr;
    logic [dssw_pkg::DATA_W-1:0] r_out_data;
    logic                        r_out_last;

    assign w_out_free = !r_out_v || i_ready;

    dssw_div10 u_div10 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    dssw_seq #(
        .NUM_DIGITS   (NUM_DIGITS),
        .VALUE_DIGITS (VALUE_DIGITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_freq       (i_freq),
        .i_cw         (i_cw),
        .i_menu_id    (i_menu_id),
        .i_menu_value (i_menu_value),
        .i_edit_mark  (i_edit_mark),
        .i_level      (i_level),
        .i_out_free   (w_out_free),
        .o_push       (w_push),
        .o_div_req    (w_div_req),
        .i_div_rsp    (w_div_rsp)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_push.valid) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
        if (w_push.valid) begin
            r_out_addr <= w_push.addr;
            r_out_data <= w_push.data;
            r_out_last <= w_push.last;
        end
    end

    assign o_valid      = r_out_v;
    assign o_reg_addr   = r_out_addr;
    assign o_reg_data   = r_out_data;
    assign o_last_write = r_out_last;

endmodule

### hw/rtl/dssw_div10.sv
// Shared divide-by-ten unit: registered quotient and remainder.
// Stage one multiplies by the scaled reciprocal, stage two forms the remainder.
// Depends on dssw_pkg.
`timescale 1ns / 1ps

module dssw_div10 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dssw_pkg::t_div_req i_req,
    output dssw_pkg::t_div_rsp o_rsp
);

    logic [dssw_pkg::PROD_W-1:0]  w_prod;
    logic [dssw_pkg::QUOT_W-1:0]  r_q1;
    logic [dssw_pkg::DIGIT_W-1:0] r_x1;
    logic                         r_v1;
    logic [dssw_pkg::DIGIT_W-1:0] w_q10;
    logic [dssw_pkg::FREQ_W-1:0]  r_q;
    logic [dssw_pkg::DIGIT_W-1:0] r_r;
    logic                         r_valid;

    // reciprocal multiply
    assign w_prod = dssw_pkg::PROD_W'(i_req.x) * dssw_pkg::PROD_W'(dssw_pkg::DIV_RECIP);

    // low four bits of ten times the quotient
    assign w_q10 = {r_q1[0], 3'b000} + {r_q1[2:0], 1'b0};

    // stage one: product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_req.start;
        end
        if (i_req.start) begin
            r_q1 <= w_prod[dssw_pkg::PROD_W-1:dssw_pkg::DIV_SHIFT];
            r_x1 <= i_req.x[dssw_pkg::DIGIT_W-1:0];
        end
    end

    // stage two: quotient and remainder, valid until the next start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.start) begin
            r_valid <= 1'b0;
        end else if (r_v1) begin
            r_valid <= 1'b1;
        end
        if (r_v1) begin
            r_q <= dssw_pkg::FREQ_W'(r_q1);
            r_r <= r_x1 - w_q10;
        end
    end

    assign o_rsp.valid = r_valid;
    assign o_rsp.q     = r_q;
    assign o_rsp.r     = r_r;

endmodule

### hw/rtl/dssw_seq.sv
// Command sequencer: walks frequency and menu digits through the divide unit
// and emits register writes, holding one back so the final one can be marked.
// Depends on dssw_pkg.
`timescale 1ns / 1ps

module dssw_seq #(
    parameter int NUM_DIGITS   = dssw_pkg::NUM_DIGITS_DEF,
    parameter int VALUE_DIGITS = dssw_pkg::VALUE_DIGITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [dssw_pkg::FUNC_W-1:0]    i_func,
    input  logic [dssw_pkg::FREQ_W-1:0]    i_freq,
    input  logic                           i_cw,
    input  logic [dssw_pkg::ID_W-1:0]      i_menu_id,
    input  logic signed [dssw_pkg::VALUE_W-1:0] i_menu_value,
    input  logic                           i_edit_mark,
    input  logic [dssw_pkg::LEVEL_W-1:0]   i_level,
    input  logic                           i_out_free,
    output dssw_pkg::t_wr                  o_push,
    output dssw_pkg::t_div_req             o_div_req,
    input  dssw_pkg::t_div_rsp             i_div_rsp
);

    localparam logic [dssw_pkg::ADDR_W-1:0] POS_LAST  = dssw_pkg::ADDR_W'(NUM_DIGITS);
    localparam logic [dssw_pkg::ADDR_W-1:0] POS_ID_LO = dssw_pkg::ADDR_W'(NUM_DIGITS - 1);
    localparam logic [dssw_pkg::ADDR_W-1:0] POS_VLAST = dssw_pkg::ADDR_W'(VALUE_DIGITS);

    dssw_pkg::t_state r_state, n_state;

    logic [dssw_pkg::FREQ_W-1:0]  r_shown_freq, n_shown_freq;
    logic                         r_shown_cw, n_shown_cw;
    logic                         r_shown_valid, n_shown_valid;
    logic [dssw_pkg::LVL_W-1:0]   r_prev_level, n_prev_level;
    logic                         r_cw, n_cw;
    logic                         r_edit, n_edit;
    logic                         r_neg, n_neg;
    logic [dssw_pkg::VALUE_W-1:0] r_mag, n_mag;
    logic [dssw_pkg::LVL_W-1:0]   r_lvl, n_lvl;
    logic [dssw_pkg::ADDR_W-1:0]  r_pos, n_pos;
    logic [dssw_pkg::FREQ_W-1:0]  r_rest, n_rest;
    logic [dssw_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                         r_pend_v, n_pend_v;
    logic [dssw_pkg::ADDR_W-1:0]  r_pend_addr, n_pend_addr;
    logic [dssw_pkg::DATA_W-1:0]  r_pend_data, n_pend_data;

    logic                         w_prod;
    logic [dssw_pkg::ADDR_W-1:0]  w_waddr;
    logic [dssw_pkg::DATA_W-1:0]  w_wdata;
    logic                         w_flush;
    logic                         w_can;
    logic                         w_skip;
    logic [dssw_pkg::LVL_W-1:0]   w_lvl;
    logic [dssw_pkg::DATA_W-1:0]  w_digit_pat;
    logic                         w_point;
    logic                         w_keep;

    // a new write may be made once any held write has room to move on
    assign w_can   = !r_pend_v || i_out_free;
    assign w_skip  = r_shown_valid && (i_freq == r_shown_freq) && (i_cw == r_shown_cw);
    assign w_lvl   = (i_level > dssw_pkg::LEVEL_W'(dssw_pkg::LVL_MAX)) ? dssw_pkg::LVL_MAX
                                                                      : i_level[3:0];
    assign w_digit_pat = dssw_pkg::seg_font(i_div_rsp.r);
    assign w_point = (r_pos == 4'd1 && r_cw) || r_pos == dssw_pkg::POINT_POS_A
                     || r_pos == dssw_pkg::POINT_POS_B;
    assign w_keep  = w_prod && (r_cnt != dssw_pkg::MAX_WRITES);
    assign o_ready = (r_state == dssw_pkg::ST_IDLE);

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= dssw_pkg::ST_IDLE;
            r_shown_freq  <= '0;
            r_shown_cw    <= 1'b0;
            r_shown_valid <= 1'b0;
            r_prev_level  <= '0;
            r_cnt         <= '0;
            r_pend_v      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_shown_freq  <= n_shown_freq;
            r_shown_cw    <= n_shown_cw;
            r_shown_valid <= n_shown_valid;
            r_prev_level  <= n_prev_level;
            r_cnt         <= n_cnt;
            r_pend_v      <= n_pend_v;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_cw        <= n_cw;
        r_edit      <= n_edit;
        r_neg       <= n_neg;
        r_mag       <= n_mag;
        r_lvl       <= n_lvl;
        r_pos       <= n_pos;
        r_rest      <= n_rest;
        r_pend_addr <= n_pend_addr;
        r_pend_data <= n_pend_data;
    end

    // next state and write generation
    always_comb begin
        n_state       = r_state;
        n_shown_freq  = r_shown_freq;
        n_shown_cw    = r_shown_cw;
        n_shown_valid = r_shown_valid;
        n_prev_level  = r_prev_level;
        n_cw          = r_cw;
        n_edit        = r_edit;
        n_neg         = r_neg;
        n_mag         = r_mag;
        n_lvl         = r_lvl;
        n_pos         = r_pos;
        n_rest        = r_rest;
        n_cnt         = r_cnt;
        n_pend_v      = r_pend_v;
        n_pend_addr   = r_pend_addr;
        n_pend_data   = r_pend_data;
        w_prod        = 1'b0;
        w_waddr       = r_pos;
        w_wdata       = dssw_pkg::SEG_BLANK;
        w_flush       = 1'b0;
        o_div_req.start = 1'b0;
        o_div_req.x     = i_div_rsp.q;

        unique case (r_state)
            dssw_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_cnt = '0;
                    unique case (i_func)
                        dssw_pkg::FUNC_FREQ: begin
                            if (!w_skip) begin
                                n_shown_freq    = i_freq;
                                n_shown_cw      = i_cw;
                                n_shown_valid   = 1'b1;
                                n_cw            = i_cw;
                                n_rest          = i_freq;
                                n_pos           = 4'd1;
                                o_div_req.start = 1'b1;
                                o_div_req.x     = i_freq;
                                n_state         = dssw_pkg::ST_FREQ;
                            end
                        end
                        dssw_pkg::FUNC_MENU: begin
                            n_shown_freq    = '0;
                            n_shown_cw      = 1'b0;
                            n_shown_valid   = 1'b0;
                            n_edit          = i_edit_mark;
                            n_neg           = i_menu_value[dssw_pkg::VALUE_W-1];
                            n_mag           = i_menu_value[dssw_pkg::VALUE_W-1]
                                              ? dssw_pkg::VALUE_W'(-i_menu_value)
                                              : dssw_pkg::VALUE_W'(i_menu_value);
                            n_pos           = 4'd1;
                            o_div_req.start = 1'b1;
                            o_div_req.x     = dssw_pkg::FREQ_W'(i_menu_id);
                            n_state         = dssw_pkg::ST_CLEAR;
                        end
                        dssw_pkg::FUNC_LEVEL: begin
                            n_lvl        = w_lvl;
                            n_prev_level = w_lvl;
                            n_state      = (w_lvl == '0 || r_prev_level == '0)
                                           ? dssw_pkg::ST_LEVEL_ON : dssw_pkg::ST_LEVEL_SET;
                        end
                        default: ;
                    endcase
                end
            end
            dssw_pkg::ST_FREQ: begin
                if (i_div_rsp.valid && w_can) begin
                    w_prod  = 1'b1;
                    w_waddr = r_pos;
                    if (r_rest != '0) begin
                        w_wdata = w_digit_pat | (w_point ? dssw_pkg::SEG_POINT
                                                         : dssw_pkg::SEG_BLANK);
                    end
                    o_div_req.start = 1'b1;
                    n_rest  = i_div_rsp.q;
                    n_pos   = r_pos + 4'd1;
                    if (r_pos == POS_LAST) begin
                        n_state = dssw_pkg::ST_FLUSH;
                    end
                end
            end
            dssw_pkg::ST_CLEAR: begin
                if (w_can) begin
                    w_prod  = 1'b1;
                    w_waddr = r_pos;
                    n_pos   = r_pos + 4'd1;
                    if (r_pos == POS_LAST) begin
                        n_state = dssw_pkg::ST_ID_LO;
                    end
                end
            end
            dssw_pkg::ST_ID_LO: begin
                if (i_div_rsp.valid && w_can) begin
                    w_prod  = 1'b1;
                    w_waddr = POS_ID_LO;
                    w_wdata = w_digit_pat | (r_edit ? dssw_pkg::SEG_POINT : dssw_pkg::SEG_BLANK);
                    o_div_req.start = 1'b1;
                    n_state = dssw_pkg::ST_ID_HI;
                end
            end
            dssw_pkg::ST_ID_HI: begin
                if (i_div_rsp.valid && w_can) begin
                    w_prod  = 1'b1;
                    w_waddr = POS_LAST;
                    w_wdata = w_digit_pat;
                    o_div_req.start = 1'b1;
                    o_div_req.x     = dssw_pkg::FREQ_W'(r_mag);
                    n_rest  = dssw_pkg::FREQ_W'(r_mag);
                    n_pos   = 4'd1;
                    n_state = dssw_pkg::ST_VALUE;
                end
            end
            dssw_pkg::ST_VALUE: begin
                if (i_div_rsp.valid && w_can) begin
                    w_waddr = r_pos;
                    if (r_rest != '0) begin
                        w_prod  = 1'b1;
                        w_wdata = w_digit_pat;
                        o_div_req.start = 1'b1;
                        n_rest  = i_div_rsp.q;
                        n_pos   = r_pos + 4'd1;
                        if (r_pos == POS_VLAST) begin
                            n_state = dssw_pkg::ST_FLUSH;
                        end
                    end else begin
                        // minus after the digits, or a lone zero for a zero value
                        if (r_neg) begin
                            w_prod  = 1'b1;
                            w_wdata = dssw_pkg::SEG_MINUS;
                        end else if (r_pos == 4'd1) begin
                            w_prod  = 1'b1;
                            w_wdata = dssw_pkg::seg_font(4'd0);
                        end
                        n_state = dssw_pkg::ST_FLUSH;
                    end
                end
            end
            dssw_pkg::ST_LEVEL_ON: begin
                if (w_can) begin
                    w_prod  = 1'b1;
                    w_waddr = dssw_pkg::ADDR_SHUTDOWN;
                    w_wdata = (r_lvl == '0) ? 8'd0 : 8'd1;
                    n_state = (r_lvl == '0) ? dssw_pkg::ST_FLUSH : dssw_pkg::ST_LEVEL_SET;
                end
            end
            dssw_pkg::ST_LEVEL_SET: begin
                if (w_can) begin
                    w_prod  = 1'b1;
                    w_waddr = dssw_pkg::ADDR_INTENSITY;
                    w_wdata = dssw_pkg::DATA_W'(r_lvl);
                    n_state = dssw_pkg::ST_FLUSH;
                end
            end
            dssw_pkg::ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = dssw_pkg::ST_IDLE;
                end else if (i_out_free) begin
                    w_flush  = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = dssw_pkg::ST_IDLE;
                end
            end
            default: n_state = dssw_pkg::ST_IDLE;
        endcase

        // hold the new write back; writes past the cap are dropped
        if (w_keep) begin
            n_pend_v    = 1'b1;
            n_pend_addr = w_waddr;
            n_pend_data = w_wdata;
            n_cnt       = r_cnt + 4'd1;
        end
    end

    // held write moves to the output register
    assign o_push.valid = (w_keep && r_pend_v) || w_flush;
    assign o_push.last  = w_flush;
    assign o_push.addr  = r_pend_addr;
    assign o_push.data  = r_pend_data;

endmodule
